// File: sv/obp_pkg.sv
// Shared types and constants for the optimal block partition unit.
// No dependencies; imported by every module of the unit except obp_ram.
`timescale 1ns / 1ps
`default_nettype none
package obp_pkg;

	localparam int DEF_MAX_SEQUENCE     = 1024;
	localparam int DEF_MAX_BLOCK_LENGTH = 64;

	localparam int ELEM_W     = 6;
	localparam int FIELD_IDX_W = 11;
	localparam int COST_W     = 32;
	localparam int WORD_SHIFT = 5;   // 32-bit words
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;

	// register indexes, at byte address 8*index
	localparam logic [1:0] REG_ALLOWED  = 2'd0;
	localparam logic [1:0] REG_ZERO_RUN = 2'd1;
	localparam logic [1:0] REG_ALIGNED  = 2'd2;
	localparam logic [1:0] REG_OVERHEAD = 2'd3;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_UNREACHABLE = 2'd1;
	localparam logic [1:0] STATUS_RANGE       = 2'd2;
	localparam logic [1:0] STATUS_OVERFLOW    = 2'd3;

	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_READ = 1'b1;

	typedef struct packed {
		logic [63:0] allowed_mask;
		logic [63:0] zero_mask;
		logic        aligned;
		logic [15:0] overhead;
	} obp_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_INIT,
		ST_ROW,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_ROW_END,
		ST_CHECK,
		ST_CHECK_WAIT,
		ST_COUNT,
		ST_COUNT_WAIT,
		ST_WALK,
		ST_WALK_WAIT,
		ST_FINISH
	} obp_state_t;

	typedef struct packed {
		logic load;
		logic read_req;
		logic read_done;
		logic finish_ovf;
		logic calc_init;
		logic row_init;
		logic scan;
		logic row_end;
		logic chk_issue;
		logic chk_take;
		logic finish_unreach;
		logic cnt_step;
		logic walk_init;
		logic walk;
		logic walk_step;
		logic finish_ok;
	} obp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic ovf_now;
		logic scan_last;
		logic row_last;
		logic n_reached;
		logic pos_zero;
		logic idx_zero;
	} obp_sts_t;

endpackage
`default_nettype wire

// File: sv/optimal_block_partition_dp_unit.sv
// Optimal block partition unit: top level with APB register file.
// Depends on obp_pkg, obp_ctrl, obp_dp (and obp_ram through obp_dp).
//
// Stream in element widths with tuser=0 (load); the transfer with tlast=1
// closes the sequence and starts a shortest-path search for the cheapest
// split into blocks. Exactly one result transfer follows the last element:
// block count, total cost, boundary 0 and a status. A transfer with tuser=1
// reads boundary read_index of the stored partition and always yields one
// result. The search is serial over one port per memory: a start state,
// then for each position i a setup state, one element/cost read for each
// of the min(i, MAX_BLOCK_LENGTH) candidate lengths, a two-stage cost
// pipeline to drain and one write-back; then a check that the end is
// reachable, a walk that counts the chain and one that writes the
// boundaries. Results sit in an output register; the input side only
// stalls while that register is full and not being taken, in the state
// that follows a read, or while a search runs. Configuration must only
// be written while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none
module optimal_block_partition_dp_unit #(
	parameter int MAX_SEQUENCE     = obp_pkg::DEF_MAX_SEQUENCE,
	parameter int MAX_BLOCK_LENGTH = obp_pkg::DEF_MAX_BLOCK_LENGTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input stream
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [23:0]                     s_axis_tdata,  // element_width[5:0], read_index[16:6]
	input  wire logic                            s_axis_tlast,  // is_last
	input  wire logic                            s_axis_tuser,  // action
	// result stream
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [55:0]                          m_axis_tdata,  // block_count[10:0], total_cost[42:11],
	                                                            // boundary[53:43], status[55:54]
	// configuration
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [obp_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [obp_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [obp_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                 pready
);
	import obp_pkg::*;

	obp_cfg_t cfg_q;
	obp_cmd_t cmd;
	obp_sts_t sts;

	logic                   in_fire;
	logic [1:0]             reg_sel;
	logic [FIELD_IDX_W-1:0] out_count, out_boundary;
	logic [COST_W-1:0]      out_total;
	logic [1:0]             out_status;

	// --- register file: 64-bit registers at 8-byte strides
	assign pready  = 1'b1;
	assign reg_sel = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allowed_mask <= 64'd1;
			cfg_q.zero_mask    <= '0;
			cfg_q.aligned      <= 1'b0;
			cfg_q.overhead     <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_ALLOWED:  cfg_q.allowed_mask <= pwdata;
				REG_ZERO_RUN: cfg_q.zero_mask    <= pwdata;
				REG_ALIGNED:  cfg_q.aligned      <= pwdata[0];
				REG_OVERHEAD: cfg_q.overhead     <= pwdata[15:0];
				default:      cfg_q.aligned      <= cfg_q.aligned;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_ALLOWED:  prdata = cfg_q.allowed_mask;
			REG_ZERO_RUN: prdata = cfg_q.zero_mask;
			REG_ALIGNED:  prdata = {63'd0, cfg_q.aligned};
			REG_OVERHEAD: prdata = {48'd0, cfg_q.overhead};
			default:      prdata = '0;
		endcase
	end

	// --- input transfer
	assign in_fire = s_axis_tvalid && s_axis_tready;

	obp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.action  (s_axis_tuser),
		.is_last (s_axis_tlast),
		.sts     (sts),
		.in_ready(s_axis_tready),
		.cmd     (cmd)
	);

	obp_dp #(
		.MAX_SEQUENCE    (MAX_SEQUENCE),
		.MAX_BLOCK_LENGTH(MAX_BLOCK_LENGTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.element_width(s_axis_tdata[5:0]),
		.is_last      (s_axis_tlast),
		.read_index   (s_axis_tdata[16:6]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.block_count  (out_count),
		.total_cost   (out_total),
		.boundary     (out_boundary),
		.status       (out_status)
	);

	// --- result transfer, packed low field first
	assign m_axis_tdata = {out_status, out_boundary, out_total, out_count};

endmodule
`default_nettype wire

// File: sv/obp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module obp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: sv/obp_ctrl.sv
// Sequencer for the partition unit: load/read handling, DP scan, traceback.
// Depends on obp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              action,
	input  wire logic              is_last,
	input  wire obp_pkg::obp_sts_t sts,
	output logic                   in_ready,
	output obp_pkg::obp_cmd_t      cmd
);
	import obp_pkg::*;

	obp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (action == ACTION_READ) state_d = ST_READ;
					else if (is_last && !sts.ovf_now) state_d = ST_INIT;
				end
			end
			ST_READ:       state_d = ST_IDLE;
			ST_INIT:       state_d = ST_ROW;
			ST_ROW:        state_d = ST_SCAN;
			ST_SCAN:       if (sts.scan_last) state_d = ST_DRAIN1;
			ST_DRAIN1:     state_d = ST_DRAIN2;
			ST_DRAIN2:     state_d = ST_ROW_END;
			ST_ROW_END:    state_d = sts.row_last ? ST_CHECK : ST_ROW;
			ST_CHECK:      state_d = ST_CHECK_WAIT;
			ST_CHECK_WAIT: state_d = sts.n_reached ? ST_COUNT : ST_IDLE;
			ST_COUNT:      state_d = sts.pos_zero ? ST_WALK : ST_COUNT_WAIT;
			ST_COUNT_WAIT: state_d = ST_COUNT;
			ST_WALK:       state_d = sts.idx_zero ? ST_FINISH : ST_WALK_WAIT;
			ST_WALK_WAIT:  state_d = ST_WALK;
			ST_FINISH:     state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_fire) begin
					if (action == ACTION_READ) begin
						cmd.read_req = 1'b1;
					end else begin
						cmd.load       = 1'b1;
						cmd.finish_ovf = is_last && sts.ovf_now;
					end
				end
			end
			ST_READ:       cmd.read_done = 1'b1;
			ST_INIT:       cmd.calc_init = 1'b1;
			ST_ROW:        cmd.row_init  = 1'b1;
			ST_SCAN:       cmd.scan      = 1'b1;
			ST_ROW_END:    cmd.row_end   = 1'b1;
			ST_CHECK:      cmd.chk_issue = 1'b1;
			ST_CHECK_WAIT: begin
				cmd.chk_take       = sts.n_reached;
				cmd.finish_unreach = !sts.n_reached;
			end
			ST_COUNT:      cmd.walk_init = sts.pos_zero;
			ST_COUNT_WAIT: cmd.cnt_step  = 1'b1;
			ST_WALK:       cmd.walk      = 1'b1;
			ST_WALK_WAIT:  cmd.walk_step = 1'b1;
			ST_FINISH:     cmd.finish_ok = 1'b1;
			default:       cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/obp_dp.sv
// Datapath: element/cost/predecessor/boundary RAMs, scan pipeline,
// traceback counters and result register. Depends on obp_pkg, obp_ram.
`timescale 1ns / 1ps
`default_nettype none
module obp_dp #(
	parameter int MAX_SEQUENCE     = obp_pkg::DEF_MAX_SEQUENCE,
	parameter int MAX_BLOCK_LENGTH = obp_pkg::DEF_MAX_BLOCK_LENGTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire obp_pkg::obp_cfg_t                   cfg,
	input  wire obp_pkg::obp_cmd_t                   cmd,
	output obp_pkg::obp_sts_t                        sts,
	input  wire logic [obp_pkg::ELEM_W-1:0]          element_width,
	input  wire logic                                is_last,
	input  wire logic [obp_pkg::FIELD_IDX_W-1:0]     read_index,
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic [obp_pkg::FIELD_IDX_W-1:0]          block_count,
	output logic [obp_pkg::COST_W-1:0]               total_cost,
	output logic [obp_pkg::FIELD_IDX_W-1:0]          boundary,
	output logic [1:0]                               status
);
	import obp_pkg::*;

	localparam int CW  = $clog2(MAX_SEQUENCE + 1);
	localparam int LW  = $clog2(MAX_BLOCK_LENGTH + 1);
	localparam int PW  = LW + ELEM_W;
	localparam int WAW = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
	localparam int SW  = COST_W + 2;
	localparam logic [SW-1:0] COST_SAT = {2'b00, {COST_W{1'b1}}};

	logic [CW-1:0] loaded_q, n_q, i_q, cnt_q, pos_q, idx_q, result_count_q;
	logic          ovf_q;
	logic [LW-1:0] len_q, lim_q;
	logic [CW-1:0] j;

	logic [ELEM_W-1:0] w_rdata, maxw_q, maxw_new;
	logic [COST_W:0]   cost_rdata;
	logic [CW-1:0]     pred_rdata, bnd_rdata;

	logic              v_s1, v_s2;
	logic [LW-1:0]     len_s1;
	logic [CW-1:0]     j_s1, j_s2;
	logic [PW-1:0]     prod_s2;
	logic [COST_W-1:0] cost_s2;

	logic              best_v_q;
	logic [COST_W-1:0] best_c_q, tot_tmp_q, stored_total_q;
	logic [CW-1:0]     best_p_q;
	logic              rd_ok_q;

	logic [5:0]        mask_bit;
	logic              len_ok;
	logic [PW-1:0]     payload;
	logic [SW-1:0]     sum;
	logic [COST_W-1:0] cand;

	assign j = i_q - CW'(len_q);

	// element widths
	obp_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_SEQUENCE)) u_width_ram (
		.clk  (clk),
		.we   (cmd.load && (32'(loaded_q) < 32'(MAX_SEQUENCE))),
		.waddr(WAW'(loaded_q)),
		.wdata(element_width),
		.raddr(WAW'(j)),
		.rdata(w_rdata)
	);

	// {reached, best cost} per position
	obp_ram #(.WIDTH(COST_W + 1), .DEPTH(MAX_SEQUENCE + 1)) u_cost_ram (
		.clk  (clk),
		.we   (cmd.calc_init || cmd.row_end),
		.waddr(cmd.calc_init ? CW'(0) : i_q),
		.wdata(cmd.calc_init ? {1'b1, {COST_W{1'b0}}} : {best_v_q, best_c_q}),
		.raddr(cmd.chk_issue ? n_q : j),
		.rdata(cost_rdata)
	);

	obp_ram #(.WIDTH(CW), .DEPTH(MAX_SEQUENCE + 1)) u_pred_ram (
		.clk  (clk),
		.we   (cmd.row_end),
		.waddr(i_q),
		.wdata(best_p_q),
		.raddr(pos_q),
		.rdata(pred_rdata)
	);

	obp_ram #(.WIDTH(CW), .DEPTH(MAX_SEQUENCE + 1)) u_bnd_ram (
		.clk  (clk),
		.we   (cmd.walk),
		.waddr(idx_q),
		.wdata(pos_q),
		.raddr(CW'(read_index)),
		.rdata(bnd_rdata)
	);

	// stage 1: running max and length check
	always_comb begin
		maxw_new = (w_rdata > maxw_q) ? w_rdata : maxw_q;
		mask_bit = 6'(len_s1 - LW'(1));
		len_ok   = cfg.allowed_mask[mask_bit] ||
			((maxw_new == '0) && cfg.zero_mask[mask_bit]);
	end

	// stage 2: candidate cost, saturating
	always_comb begin
		payload = cfg.aligned ? ((prod_s2 + PW'(31)) >> WORD_SHIFT) : prod_s2;
		sum     = SW'(cost_s2) + SW'(payload) + SW'(cfg.overhead);
		cand    = (sum > COST_SAT) ? {COST_W{1'b1}} : sum[COST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan;
			v_s2 <= v_s1 && len_ok && cost_rdata[COST_W];
		end
	end

	always_ff @(posedge clk) begin
		len_s1  <= len_q;
		j_s1    <= j;
		prod_s2 <= PW'(len_s1) * PW'(maxw_new);
		cost_s2 <= cost_rdata[COST_W-1:0];
		j_s2    <= j_s1;

		if (cmd.row_init) maxw_q <= '0;
		else if (v_s1) maxw_q <= maxw_new;

		if (cmd.row_init) begin
			best_v_q <= 1'b0;
		end else if (v_s2 && (!best_v_q || cand <= best_c_q)) begin
			best_v_q <= 1'b1;
			best_c_q <= cand;
			best_p_q <= j_s2;
		end

		if (cmd.row_init) begin
			len_q <= LW'(1);
			lim_q <= (32'(i_q) >= 32'(MAX_BLOCK_LENGTH)) ? LW'(MAX_BLOCK_LENGTH)
				: LW'(i_q);
		end else if (cmd.scan) begin
			len_q <= len_q + LW'(1);
		end

		if (cmd.calc_init) i_q <= CW'(1);
		else if (cmd.row_end) i_q <= i_q + CW'(1);

		if (cmd.load && is_last) n_q <= loaded_q + CW'(1);

		if (cmd.chk_take) begin
			tot_tmp_q <= cost_rdata[COST_W-1:0];
			cnt_q     <= '0;
			pos_q     <= n_q;
		end else if (cmd.cnt_step) begin
			pos_q <= pred_rdata;
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.walk_init) begin
			idx_q <= cnt_q;
			pos_q <= n_q;
		end else if (cmd.walk_step) begin
			pos_q <= pred_rdata;
			idx_q <= idx_q - CW'(1);
		end

		if (cmd.read_req) begin
			rd_ok_q <= (result_count_q != '0) &&
				(32'(read_index) <= 32'(result_count_q));
		end
	end

	// load counter, stored partition, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q       <= '0;
			ovf_q          <= 1'b0;
			result_count_q <= '0;
			stored_total_q <= '0;
			out_valid      <= 1'b0;
			block_count    <= '0;
			total_cost     <= '0;
			boundary       <= '0;
			status         <= STATUS_OK;
		end else begin
			if (cmd.load) begin
				if (is_last) begin
					loaded_q <= '0;
					ovf_q    <= 1'b0;
				end else if (32'(loaded_q) < 32'(MAX_SEQUENCE)) begin
					loaded_q <= loaded_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end

			if (cmd.finish_ovf || cmd.finish_unreach) begin
				result_count_q <= '0;
				stored_total_q <= '0;
			end else if (cmd.finish_ok) begin
				result_count_q <= cnt_q;
				stored_total_q <= tot_tmp_q;
			end

			if (cmd.finish_ovf || cmd.finish_unreach) begin
				out_valid   <= 1'b1;
				block_count <= '0;
				total_cost  <= '0;
				boundary    <= '0;
				status      <= cmd.finish_ovf ? STATUS_OVERFLOW : STATUS_UNREACHABLE;
			end else if (cmd.finish_ok) begin
				out_valid   <= 1'b1;
				block_count <= FIELD_IDX_W'(cnt_q);
				total_cost  <= tot_tmp_q;
				boundary    <= '0;
				status      <= STATUS_OK;
			end else if (cmd.read_done) begin
				out_valid   <= 1'b1;
				block_count <= FIELD_IDX_W'(result_count_q);
				total_cost  <= stored_total_q;
				boundary    <= rd_ok_q ? FIELD_IDX_W'(bnd_rdata) : '0;
				status      <= rd_ok_q ? STATUS_OK : STATUS_RANGE;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.out_free  = !out_valid || out_ready;
		sts.ovf_now   = ovf_q || (32'(loaded_q) >= 32'(MAX_SEQUENCE));
		sts.scan_last = (len_q == lim_q);
		sts.row_last  = (i_q == n_q);
		sts.n_reached = cost_rdata[COST_W];
		sts.pos_zero  = (pos_q == '0);
		sts.idx_zero  = (idx_q == '0);
	end

endmodule
`default_nettype wire

// File: sim/tb_optimal_block_partition_dp_unit.sv
// Self-checking testbench for optimal_block_partition_dp_unit: a directed table, then random
// sequences and boundary reads, checked against a behavioral partition search in this file.
// Depends on obp_pkg and the unit RTL only.
`timescale 1ns / 1ps
module tb_optimal_block_partition_dp_unit;
	import obp_pkg::*;

	localparam int SEQ_MAX   = 1024;
	localparam int BLK_MAX   = 64;
	localparam int N_ITEMS   = 1100;
	localparam int CYCLE_LIMIT = 4_000_000;

	typedef struct {
		bit [10:0] blocks;
		bit [31:0] cost;
		bit [10:0] bnd;
		bit [1:0]  st;
	} part_res_t;

	typedef struct {
		bit        action;
		bit [5:0]  ew;
		bit        last;
		bit [10:0] idx;
		bit        typed;    // expected result given by hand
		part_res_t res;
	} part_item_t;

	// directed rows: either a stream transfer or a register write
	typedef struct {
		bit         is_cfg;
		logic [1:0] reg_idx;
		bit [63:0]  reg_val;
		part_item_t it;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic        pready;

	optimal_block_partition_dp_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Behavioral partition model: config copy and its own state
	// ---------------------------------------------------------------
	bit [63:0] len_mask = 64'h1;
	bit [63:0] zrun_mask = 64'h0;
	bit        aligned_cfg = 1'b0;
	bit [15:0] blk_overhead = 16'h0;

	bit [5:0]  elem_widths[SEQ_MAX];
	bit [31:0] path_cost[SEQ_MAX+1];
	int        path_pred[SEQ_MAX+1];
	bit        path_ok[SEQ_MAX+1];
	bit [10:0] part_bounds[SEQ_MAX+1];
	int        n_loaded = 0;
	int        n_blocks = 0;
	bit        seq_overflow = 1'b0;
	bit [31:0] part_total = '0;

	function automatic bit [31:0] sat_add(bit [31:0] a, bit [63:0] b);
		bit [63:0] s;
		s = {32'h0, a} + b;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic bit len_allowed(bit [63:0] mask, int len);
		if (len < 1 || len > BLK_MAX)
			return 1'b0;
		return mask[len-1];
	endfunction

	// shortest-path search over n loaded widths; returns status
	function automatic bit [1:0] search_partition(int n);
		int i, len, j, maxw, cnt, pos;
		bit [63:0] payload;
		bit [31:0] cand;
		n_blocks = 0;
		part_total = '0;
		path_ok[0] = 1'b1;
		path_cost[0] = '0;
		path_pred[0] = 0;
		for (i = 1; i <= n; i++) begin
			maxw = 0;
			path_ok[i] = 1'b0;
			path_cost[i] = '0;
			path_pred[i] = 0;
			for (len = 1; len <= BLK_MAX && len <= i; len++) begin
				j = i - len;
				if (elem_widths[j] > maxw)
					maxw = elem_widths[j];
				if (!(len_allowed(len_mask, len) || (maxw == 0 && len_allowed(zrun_mask, len))))
					continue;
				if (!path_ok[j])
					continue;
				payload = len * maxw;
				if (aligned_cfg)
					payload = (payload + 31) / 32;
				cand = sat_add(sat_add(path_cost[j], payload), {48'h0, blk_overhead});
				// <= keeps the longer block on a tie
				if (!path_ok[i] || cand <= path_cost[i]) begin
					path_ok[i] = 1'b1;
					path_cost[i] = cand;
					path_pred[i] = j;
				end
			end
		end
		if (!path_ok[n])
			return STATUS_UNREACHABLE;
		cnt = 0;
		pos = n;
		while (pos != 0 && cnt < n) begin
			pos = path_pred[pos];
			cnt++;
		end
		pos = n;
		part_bounds[0] = '0;
		for (i = cnt; i >= 1; i--) begin
			part_bounds[i] = pos[10:0];
			pos = path_pred[pos];
		end
		n_blocks = cnt;
		part_total = path_cost[n];
		return STATUS_OK;
	endfunction

	task automatic model_step(input part_item_t it, output bit has, output part_res_t r);
		r = '{default: '0};
		has = 1'b1;
		if (it.action == ACTION_LOAD) begin
			if (n_loaded < SEQ_MAX) begin
				elem_widths[n_loaded] = it.ew;
				n_loaded++;
			end else begin
				seq_overflow = 1'b1;
			end
			if (!it.last) begin
				has = 1'b0;
				return;
			end
			if (seq_overflow || n_loaded == 0) begin
				n_blocks = 0;
				part_total = '0;
				r.st = STATUS_OVERFLOW;
			end else begin
				r.st = search_partition(n_loaded);
			end
			n_loaded = 0;
			seq_overflow = 1'b0;
		end else begin
			if (n_blocks != 0 && it.idx <= n_blocks) begin
				r.bnd = part_bounds[it.idx];
				r.st = STATUS_OK;
			end else begin
				r.st = STATUS_RANGE;
			end
		end
		r.blocks = n_blocks[10:0];
		r.cost = part_total;
	endtask

	// ---------------------------------------------------------------
	// Sender: pops items, random gaps, predicts on each accepted transfer
	// ---------------------------------------------------------------
	part_item_t item_q[$];
	part_res_t  result_q[$];
	part_item_t cur_item;
	bit         offering = 1'b0;
	bit         calm = 1'b0;     // no gaps on either side
	int         send_gap = 0;
	int         n_errors = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		bit        has;
		part_res_t r;
		if (arst_n) begin
			if (offering && s_axis_tready) begin
				model_step(cur_item, has, r);
				if (has)
					result_q.insert(result_q.size(), cur_item.typed ? cur_item.res : r);
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (item_q.size() != 0) begin
					cur_item = item_q.pop_front();
					offering = 1'b1;
					send_gap = pick_gap();
				end
			end
		end
		s_axis_tvalid <= offering;
		s_axis_tuser  <= cur_item.action;
		s_axis_tlast  <= cur_item.last;
		s_axis_tdata  <= {7'h0, cur_item.idx, cur_item.ew};
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls, one long hold on request, checks results
	// ---------------------------------------------------------------
	int hold_ask = 0;
	int hold_seen = 0;
	int long_hold = 0;
	int rcv_gap = 0;

	always @(posedge clk) begin
		part_res_t exp_r;
		bit        rdy;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_q.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_axis_tdata);
				n_errors++;
			end else begin
				exp_r = result_q.pop_front();
				if (m_axis_tdata[10:0] != exp_r.blocks) begin
					$error("block_count exp %0d got %0d", exp_r.blocks, m_axis_tdata[10:0]);
					n_errors++;
				end
				if (m_axis_tdata[42:11] != exp_r.cost) begin
					$error("total_cost exp %0d got %0d", exp_r.cost, m_axis_tdata[42:11]);
					n_errors++;
				end
				if (m_axis_tdata[53:43] != exp_r.bnd) begin
					$error("boundary exp %0d got %0d", exp_r.bnd, m_axis_tdata[53:43]);
					n_errors++;
				end
				if (m_axis_tdata[55:54] != exp_r.st) begin
					$error("status exp %0d got %0d", exp_r.st, m_axis_tdata[55:54]);
					n_errors++;
				end
			end
		end
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			long_hold = 400;
		end
		if (long_hold > 0) begin
			long_hold--;
			rdy = 1'b0;
		end else if (rcv_gap > 0) begin
			rcv_gap--;
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
			rcv_gap = pick_gap();
		end
		m_axis_tready <= rdy;
	end

	// run limit
	int n_cycles = 0;
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic part_item_t mk_item(bit action, bit [5:0] ew, bit last, bit [10:0] idx);
		part_item_t it;
		it = '{default: '0};
		it.action = action;
		it.ew = ew;
		it.last = last;
		it.idx = idx;
		return it;
	endfunction

	// everything sent, every result back, then a pause for the search to settle
	task automatic wait_drained();
		do @(posedge clk);
		while (item_q.size() != 0 || offering || result_q.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// setup cycle, then access cycle; the register takes the value at the access edge
	task automatic apb_write(input logic [1:0] reg_idx, input bit [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (reg_idx)
			REG_ALLOWED:  len_mask = val;
			REG_ZERO_RUN: zrun_mask = val;
			REG_ALIGNED:  aligned_cfg = val[0];
			REG_OVERHEAD: blk_overhead = val[15:0];
			default:      ;
		endcase
	endtask

	function automatic bit [5:0] rand_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 6'd0;
		if (r < 92)
			return 6'($urandom_range(0, 32));
		return 6'($urandom_range(33, 63));
	endfunction

	int n_issued = 0;
	int last_len = 1;

	// every input item goes through here so the total is counted
	task automatic queue_item(input part_item_t it);
		item_q.insert(item_q.size(), it);
		n_issued++;
	endtask

	// one sequence of loads, with a stray boundary read now and then
	task automatic push_sequence(input int len);
		int k;
		bit zero_run;
		zero_run = ($urandom_range(0, 4) == 0);
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 19) == 0) begin
				queue_item(mk_item(ACTION_READ, 6'($urandom), 1'b0,
				                   11'($urandom_range(0, last_len + 1))));
			end
			queue_item(mk_item(ACTION_LOAD,
			                   (zero_run && $urandom_range(0, 5) != 0) ? 6'd0 : rand_width(),
			                   k == len - 1, 11'($urandom)));
		end
		last_len = len;
	endtask

	task automatic random_config();
		bit [63:0] v;
		case ($urandom_range(0, 5))
			0: v = '1;
			1: v = 64'h1;
			2: v = 64'h8000_0000_0000_0000;
			3: v = 64'h0F;
			4: v = 64'h2A;                   // even lengths only
			default: v = {$urandom, $urandom} | 64'h1;
		endcase
		apb_write(REG_ALLOWED, v);
		case ($urandom_range(0, 2))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		apb_write(REG_ZERO_RUN, v);
		apb_write(REG_ALIGNED, 64'($urandom_range(0, 1)));
		case ($urandom_range(0, 2))
			0: v = 64'd0;
			1: v = 64'd65535;
			default: v = 64'($urandom_range(0, 40));
		endcase
		apb_write(REG_OVERHEAD, v);
	endtask

	// ---------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------
	function automatic dir_row_t t_item(bit action, bit [5:0] ew, bit last, bit [10:0] idx);
		dir_row_t d;
		d = '{default: '0};
		d.it = mk_item(action, ew, last, idx);
		return d;
	endfunction

	function automatic dir_row_t t_chk(bit action, bit [5:0] ew, bit last, bit [10:0] idx,
	                                   bit [10:0] blocks, bit [31:0] cost, bit [10:0] bnd,
	                                   bit [1:0] st);
		dir_row_t d;
		d = t_item(action, ew, last, idx);
		d.it.typed = 1'b1;
		d.it.res = '{blocks, cost, bnd, st};
		return d;
	endfunction

	function automatic dir_row_t t_cfg(logic [1:0] reg_idx, bit [63:0] val);
		dir_row_t d;
		d = '{default: '0};
		d.is_cfg = 1'b1;
		d.reg_idx = reg_idx;
		d.reg_val = val;
		return d;
	endfunction

	dir_row_t dir_tab[$];

	initial begin
		int k, len;
		dir_tab = '{
			// nothing stored yet: every read is out of range
			t_chk(ACTION_READ, 6'd0, 1'b0, 11'd0, 11'd0, 32'd0, 11'd0, STATUS_RANGE),
			// reset config allows length 1 only
			t_chk(ACTION_LOAD, 6'd32, 1'b1, 11'd0, 11'd1, 32'd32, 11'd0, STATUS_OK),
			t_chk(ACTION_READ, 6'd0, 1'b0, 11'd1, 11'd1, 32'd32, 11'd1, STATUS_OK),
			t_chk(ACTION_READ, 6'd0, 1'b0, 11'd2, 11'd1, 32'd32, 11'd0, STATUS_RANGE),
			t_chk(ACTION_READ, 6'h3F, 1'b1, 11'h7FF, 11'd1, 32'd32, 11'd0, STATUS_RANGE),
			t_item(ACTION_LOAD, 6'd0, 1'b0, 11'h7FF),
			t_chk(ACTION_LOAD, 6'd63, 1'b1, 11'd0, 11'd2, 32'd63, 11'd0, STATUS_OK),
			t_item(ACTION_READ, 6'd0, 1'b0, 11'd2),
			// read while a sequence is half loaded
			t_item(ACTION_LOAD, 6'd5, 1'b0, 11'd0),
			t_item(ACTION_READ, 6'd0, 1'b0, 11'd1),
			t_chk(ACTION_LOAD, 6'd7, 1'b1, 11'd0, 11'd2, 32'd12, 11'd0, STATUS_OK),
			// length 2 only: a single element cannot be covered
			t_cfg(REG_ALLOWED, 64'h2),
			t_chk(ACTION_LOAD, 6'd1, 1'b1, 11'd0, 11'd0, 32'd0, 11'd0, STATUS_UNREACHABLE),
			t_chk(ACTION_READ, 6'd0, 1'b0, 11'd0, 11'd0, 32'd0, 11'd0, STATUS_RANGE),
			// every length, word rounding, heaviest overhead
			t_cfg(REG_ALLOWED, '1),
			t_cfg(REG_ALIGNED, 64'd1),
			t_cfg(REG_OVERHEAD, 64'd65535),
			t_item(ACTION_LOAD, 6'd32, 1'b0, 11'd0),
			t_item(ACTION_LOAD, 6'd1, 1'b0, 11'd0),
			t_item(ACTION_LOAD, 6'd17, 1'b1, 11'd0),
			// zero runs: length 1 for data, any length for all-zero blocks
			t_cfg(REG_ALLOWED, 64'h1),
			t_cfg(REG_ALIGNED, 64'd0),
			t_cfg(REG_OVERHEAD, 64'd3),
			t_cfg(REG_ZERO_RUN, '1),
			t_item(ACTION_LOAD, 6'd0, 1'b0, 11'd0),
			t_item(ACTION_LOAD, 6'd0, 1'b0, 11'd0),
			t_item(ACTION_LOAD, 6'd0, 1'b0, 11'd0),
			t_item(ACTION_LOAD, 6'd9, 1'b1, 11'd0),
			t_item(ACTION_READ, 6'd0, 1'b0, 11'd1),
			t_item(ACTION_READ, 6'd0, 1'b0, 11'd2)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r]) begin
			if (dir_tab[r].is_cfg) begin
				wait_drained();
				apb_write(dir_tab[r].reg_idx, dir_tab[r].reg_val);
			end else begin
				queue_item(dir_tab[r].it);
			end
		end
		wait_drained();

		// long receiver hold while reads keep coming: the output fills and input stalls
		calm = 1'b1;
		hold_ask++;
		for (k = 0; k < 30; k++)
			queue_item(mk_item(ACTION_READ, 6'd0, 1'b0, 11'($urandom_range(0, 3))));
		wait_drained();
		calm = 1'b0;

		// one oversized sequence: 1024 loads fill the store, the next one overflows
		for (k = 0; k < SEQ_MAX + 1; k++)
			queue_item(mk_item(ACTION_LOAD, rand_width(), k == SEQ_MAX, 11'd0));
		queue_item(mk_item(ACTION_READ, 6'd0, 1'b0, 11'd0));
		wait_drained();

		// random phases, each under its own configuration
		while (n_issued < N_ITEMS) begin
			wait_drained();
			random_config();
			calm = ($urandom_range(0, 3) == 0);
			for (k = 0; k < 12 && n_issued < N_ITEMS; k++) begin
				len = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 12)
				                                   : $urandom_range(13, 150);
				push_sequence(len);
				repeat ($urandom_range(0, 4)) begin
					queue_item(mk_item(ACTION_READ, 6'($urandom), 1'($urandom),
						($urandom_range(0, 9) == 0) ? 11'($urandom)
						                            : 11'($urandom_range(0, len + 1))));
				end
			end
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// File: sim.f
sv/obp_pkg.sv
sv/obp_ram.sv
sv/obp_ctrl.sv
sv/obp_dp.sv
sv/optimal_block_partition_dp_unit.sv
sim/tb_optimal_block_partition_dp_unit.sv
